// ===== hdl/glu_pkg.sv =====
// Package for the GCD/LCM unit: widths, payload structs, sequencer states.
package glu_pkg;
    localparam int DATA_WIDTH = 64;
    localparam int CNT_W      = $clog2(DATA_WIDTH + 1);

    typedef struct packed {
        logic                  kind;
        logic [DATA_WIDTH-1:0] operand_a;
        logic [DATA_WIDTH-1:0] operand_b;
    } t_in;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] value;
        logic                  ok;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EUCLID,
        S_QUOT,
        S_MUL,
        S_DONE
    } t_state;

    localparam logic KIND_GCD = 1'b0;
    localparam logic KIND_LCM = 1'b1;
endpackage

// ===== hdl/glu_divider.sv =====
// Restoring divider, one quotient bit per cycle, shared by Euclid and LCM.
module glu_divider (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [glu_pkg::DATA_WIDTH-1:0]  i_dividend,
    input  logic [glu_pkg::DATA_WIDTH-1:0]  i_divisor,
    output logic                            o_done,
    output logic [glu_pkg::DATA_WIDTH-1:0]  o_quot,
    output logic [glu_pkg::DATA_WIDTH-1:0]  o_rem
);
    localparam int W = glu_pkg::DATA_WIDTH;

    logic [W-1:0]              r_q, r_d;
    logic [W:0]                r_r;
    logic [glu_pkg::CNT_W-1:0] r_cnt;
    logic                      r_busy;
    logic [W:0]                w_shift;
    logic [W:0]                w_diff;

    // One shift-and-subtract step.
    assign w_shift = {r_r[W-1:0], r_q[W-1]};
    assign w_diff  = w_shift - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= glu_pkg::CNT_W'(W);
                r_q    <= i_dividend;
                r_d    <= i_divisor;
                r_r    <= '0;
            end else if (r_busy) begin
                if (!w_diff[W]) begin
                    r_r <= w_diff;
                    r_q <= {r_q[W-2:0], 1'b1};
                end else begin
                    r_r <= w_shift;
                    r_q <= {r_q[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == glu_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_q;
    assign o_rem  = r_r[W-1:0];
endmodule

// ===== hdl/gcd_lcm_unit_top.sv =====
// Top level of the GCD/LCM unit: sequencer, shift-add multiplier, result register.
//
//  channel | ports                      | direction | handshake
//  input   | i_start, o_busy, i_in      | in        | start high and busy low
//  result  | o_valid, o_out             | out       | one-cycle strobe
//
// GCD runs one Euclid remainder step per pass through the bit-serial divider;
// LCM adds one more division and a shift-add multiply. A zero second operand
// skips the divider; a zero first operand still takes one remainder step.
// Reset clears the sequencer; the result strobe cannot be held off.
module gcd_lcm_unit_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  glu_pkg::t_in   i_in,
    output logic           o_busy,
    output logic           o_valid,
    output glu_pkg::t_out  o_out
);
    localparam int W = glu_pkg::DATA_WIDTH;

    glu_pkg::t_state r_state, n_state;
    logic [W-1:0]    r_x, r_y, r_a, r_b, r_acc, r_mq;
    logic            r_kind, r_ovf, r_div_go;
    logic [glu_pkg::CNT_W-1:0] r_cnt;
    logic            w_div_done;
    logic [W-1:0]    w_quot, w_rem;
    logic [W-1:0]    w_div_n, w_div_d;
    logic [W:0]      w_sum;

    assign w_div_n = (r_state == glu_pkg::S_QUOT) ? r_a : r_x;
    assign w_div_d = r_y;

    glu_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (w_div_n),
        .i_divisor  (w_div_d),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // Multiply accumulate: r_mq shifts out from the top, acc doubles and adds b.
    assign w_sum = {r_acc, 1'b0} + (r_mq[W-1] ? {1'b0, r_b} : '0);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            glu_pkg::S_IDLE:   if (i_start) n_state = glu_pkg::S_EUCLID;
            glu_pkg::S_EUCLID: if (r_y == '0) n_state =
                (r_kind == glu_pkg::KIND_LCM && r_a != '0 && r_b != '0)
                    ? glu_pkg::S_QUOT : glu_pkg::S_DONE;
            glu_pkg::S_QUOT:   if (w_div_done) n_state = glu_pkg::S_MUL;
            glu_pkg::S_MUL:    if (r_cnt == '0) n_state = glu_pkg::S_DONE;
            glu_pkg::S_DONE:   n_state = glu_pkg::S_IDLE;
            default:           n_state = glu_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= glu_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    // Datapath and divider launch control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_go <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            o_valid  <= 1'b0;
            case (r_state)
                glu_pkg::S_IDLE: if (i_start) begin
                    r_kind <= i_in.kind;
                    r_a    <= i_in.operand_a;
                    r_b    <= i_in.operand_b;
                    r_x    <= i_in.operand_a;
                    r_y    <= i_in.operand_b;
                    r_div_go <= (i_in.operand_b != '0);
                end
                glu_pkg::S_EUCLID: begin
                    if (r_y == '0) begin
                        r_div_go <= (r_kind == glu_pkg::KIND_LCM && r_a != '0
                                     && r_b != '0);
                        r_y <= r_x;
                    end else if (w_div_done) begin
                        r_x <= r_y;
                        r_y <= w_rem;
                        r_div_go <= (w_rem != '0);
                    end
                end
                glu_pkg::S_QUOT: if (w_div_done) begin
                    r_mq  <= w_quot;
                    r_acc <= '0;
                    r_ovf <= 1'b0;
                    r_cnt <= glu_pkg::CNT_W'(W);
                end
                glu_pkg::S_MUL: if (r_cnt != '0) begin
                    if (r_acc[W-1] || w_sum[W]) r_ovf <= 1'b1;
                    r_acc <= w_sum[W-1:0];
                    r_mq  <= {r_mq[W-2:0], 1'b0};
                    r_cnt <= r_cnt - 1'b1;
                end
                glu_pkg::S_DONE: begin
                    o_valid <= 1'b1;
                    if (r_kind == glu_pkg::KIND_GCD) begin
                        o_out.value <= r_x;
                        o_out.ok    <= 1'b1;
                    end else if (r_a == '0 || r_b == '0) begin
                        o_out.value <= '0;
                        o_out.ok    <= 1'b1;
                    end else begin
                        o_out.value <= r_ovf ? '0 : r_acc;
                        o_out.ok    <= !r_ovf;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_busy = (r_state != glu_pkg::S_IDLE);

    // A result strobe follows only the final sequencer step.
    a_valid_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state) == glu_pkg::S_DONE)
        else $error("result without done step");
    // GCD results always report ok.
    a_gcd_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_kind == glu_pkg::KIND_GCD) |-> o_out.ok)
        else $error("gcd result not ok");
    // An accepted start leaves the idle state.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("start not taken");
endmodule

// ===== test/tb_gcd_lcm_unit_top.sv =====
// Self-checking testbench for the GCD/LCM unit: directed table, then random operands.
`timescale 1ns / 100ps

module tb_gcd_lcm_unit_top;
    localparam int            DW       = glu_pkg::DATA_WIDTH;
    localparam logic [DW-1:0] MAX_VAL  = '1;
    localparam int            N_RANDOM = 1250;
    localparam int            N_QUIET  = 150;
    localparam int            WD_LIMIT = 50000;

    // One row of the directed table; has_exp marks rows with a typed-in answer.
    typedef struct {
        logic          kind;
        logic [DW-1:0] a;
        logic [DW-1:0] b;
        bit            has_exp;
        logic [DW-1:0] exp_value;
        logic          exp_ok;
    } t_row;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_start;
    glu_pkg::t_in   i_in;
    logic           o_busy;
    logic           o_valid;
    glu_pkg::t_out  o_out;

    glu_pkg::t_out  pending_results[$];
    int             mismatch_cnt;
    int             idle_cycles;
    bit             quiet;

    gcd_lcm_unit_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_in    (i_in),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_out   (o_out)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Euclid by repeated remainder.
    function automatic logic [DW-1:0] euclid_gcd(logic [DW-1:0] x, logic [DW-1:0] y);
        logic [DW-1:0] r;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    // Expected GCD or LCM for one operand pair, with the LCM overflow check.
    function automatic glu_pkg::t_out gcd_lcm_result(glu_pkg::t_in item);
        glu_pkg::t_out res;
        logic [DW-1:0] q;
        res.value = '0;
        res.ok    = 1'b1;
        if (item.kind == glu_pkg::KIND_GCD) begin
            res.value = euclid_gcd(item.operand_a, item.operand_b);
        end else if (item.operand_a != 0 && item.operand_b != 0) begin
            q = item.operand_a / euclid_gcd(item.operand_a, item.operand_b);
            if (q > MAX_VAL / item.operand_b) begin
                res.ok = 1'b0;
            end else begin
                res.value = q * item.operand_b;
            end
        end
        return res;
    endfunction

    // Drive one operation and hold it until the unit takes the transfer.
    task automatic issue_op(glu_pkg::t_in item, glu_pkg::t_out expected);
        i_start <= 1'b1;
        i_in    <= item;
        do @(posedge i_clk); while (o_busy);
        pending_results.push_back(expected);
    endtask

    // Random idle burst between operations, skipped in the quiet tail.
    task automatic maybe_idle();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    function automatic logic [DW-1:0] rand_bits(int width);
        logic [DW-1:0] v;
        v = {$urandom, $urandom};
        return (width >= DW) ? v : (v & ((64'd1 << width) - 1));
    endfunction

    // Random operand pair: zeros, full width, narrow, or sharing a factor.
    function automatic glu_pkg::t_in rand_item();
        glu_pkg::t_in  item;
        logic [DW-1:0] g;
        int            mode;
        item.kind = 1'($urandom_range(0, 1));
        mode      = $urandom_range(0, 9);
        case (mode)
            0: begin
                item.operand_a = ($urandom_range(0, 1) != 0) ? '0 : rand_bits(64);
                item.operand_b = (item.operand_a != 0) ? '0 : rand_bits(64);
            end
            1, 2: begin
                item.operand_a = rand_bits(64);
                item.operand_b = rand_bits(64);
            end
            3, 4, 5, 6: begin
                item.operand_a = rand_bits($urandom_range(1, 32));
                item.operand_b = rand_bits($urandom_range(1, 32));
            end
            default: begin
                g              = rand_bits($urandom_range(1, 20));
                item.operand_a = g * rand_bits($urandom_range(1, 20));
                item.operand_b = g * rand_bits($urandom_range(1, 20));
            end
        endcase
        return item;
    endfunction

    // Compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        glu_pkg::t_out exp_res;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("Unexpected result: value=%h ok=%b", o_out.value, o_out.ok);
            end else begin
                exp_res = pending_results.pop_front();
                if (o_out.value !== exp_res.value || o_out.ok !== exp_res.ok) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("Mismatch: expected value=%h ok=%b, got value=%h ok=%b",
                                 exp_res.value, exp_res.ok, o_out.value, o_out.ok);
                end
            end
        end
    end

    // Watchdog on cycles in which no transfer happens on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (i_start && !o_busy)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WD_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_row          rows[$];
        glu_pkg::t_in  item;
        glu_pkg::t_out expected;

        mismatch_cnt = 0;
        quiet        = 1'b0;
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_in         = '0;

        // Edge cases first: zeros, extremes, overflow and a long Euclid chain.
        rows = '{
            '{glu_pkg::KIND_GCD, 64'd0,   64'd0,     1, 64'd0,   1'b1},
            '{glu_pkg::KIND_GCD, 64'd12,  64'd0,     1, 64'd12,  1'b1},
            '{glu_pkg::KIND_GCD, 64'd0,   64'd35,    1, 64'd35,  1'b1},
            '{glu_pkg::KIND_GCD, MAX_VAL, MAX_VAL,   1, MAX_VAL, 1'b1},
            '{glu_pkg::KIND_GCD, 64'd1,   MAX_VAL,   1, 64'd1,   1'b1},
            '{glu_pkg::KIND_GCD, MAX_VAL, 64'd0,     1, MAX_VAL, 1'b1},
            '{glu_pkg::KIND_LCM, 64'd0,   64'd9,     1, 64'd0,   1'b1},
            '{glu_pkg::KIND_LCM, 64'd9,   64'd0,     1, 64'd0,   1'b1},
            '{glu_pkg::KIND_LCM, 64'd0,   64'd0,     1, 64'd0,   1'b1},
            '{glu_pkg::KIND_LCM, 64'd1,   MAX_VAL,   1, MAX_VAL, 1'b1},
            '{glu_pkg::KIND_LCM, MAX_VAL, MAX_VAL,   1, MAX_VAL, 1'b1},
            '{glu_pkg::KIND_LCM, MAX_VAL, MAX_VAL-1, 1, 64'd0,   1'b0},
            '{glu_pkg::KIND_LCM, 64'h1_0000_0000, 64'h1_0000_0001, 1, 64'd0, 1'b0},
            '{glu_pkg::KIND_LCM, 64'h1_0000_0000, 64'hFFFF_FFFF,   1,
              64'hFFFF_FFFF_0000_0000, 1'b1},
            '{glu_pkg::KIND_GCD, 64'd7540113804746346429, 64'd4660046610375530309,
              0, 0, 0},
            '{glu_pkg::KIND_LCM, 64'd7540113804746346429, 64'd4660046610375530309,
              0, 0, 0},
            '{glu_pkg::KIND_GCD, 64'd48,  64'd180,   0, 0, 0},
            '{glu_pkg::KIND_LCM, 64'd48,  64'd180,   0, 0, 0},
            '{glu_pkg::KIND_LCM, 64'h8000_0000_0000_0000, 64'd2, 0, 0, 0},
            '{glu_pkg::KIND_LCM, 64'h8000_0000_0000_0000, 64'd6, 0, 0, 0}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            item.kind      = rows[i].kind;
            item.operand_a = rows[i].a;
            item.operand_b = rows[i].b;
            if (rows[i].has_exp) begin
                expected.value = rows[i].exp_value;
                expected.ok    = rows[i].exp_ok;
            end else begin
                expected = gcd_lcm_result(item);
            end
            issue_op(item, expected);
            maybe_idle();
        end

        // Random operations; the tail runs back to back.
        for (int n = 0; n < N_RANDOM; n++) begin
            quiet = (n >= N_RANDOM - N_QUIET);
            item  = rand_item();
            issue_op(item, gcd_lcm_result(item));
            maybe_idle();
        end
        i_start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
